>>> hdl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`else

`define ASSERT_IMPLIES(name, ante, cons)

`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> hdl/ibpp_pkg.sv
// shared types and codes of the bitplane pixel port
`default_nettype none

package ibpp_pkg;

  localparam int NUM_PLANES = 4;
  localparam int WORD_BITS  = 16;

  // commands
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_REMAP = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // result status
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_CLIPPED = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  // access classification decided before the store read
  localparam logic [1:0] CLS_NOP    = 2'd0;
  localparam logic [1:0] CLS_CLIP   = 2'd1;
  localparam logic [1:0] CLS_RANGE  = 2'd2;
  localparam logic [1:0] CLS_ACCESS = 2'd3;

  // register indexes
  localparam logic [2:0] REG_LINE_WORDS   = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_CLIP_ENABLE  = 3'd3;
  localparam logic [2:0] REG_MASK_ENABLE  = 3'd4;
  localparam logic [2:0] REG_REMAP_TABLE  = 3'd5;

  // one 16-pixel group: four interleaved plane words and the mask word
  typedef struct packed {
    logic [NUM_PLANES*WORD_BITS-1:0] planes;
    logic [WORD_BITS-1:0]            mask;
  } word_t;

endpackage

`default_nettype wire

>>> hdl/interleaved_bitplane_pixel_port.sv
// top level of the interleaved bitplane pixel port
//
// channel  dir  handshake          payload
// in_      in   tvalid / tready    tdata: pos_x, pos_y, color, transparent; tuser: cmd
// out_     out  tvalid / tready    tdata: read_color, read_masked, changed; tuser: status
// cfg_     in   psel / penable     64-bit register writes and reads, pready always high
//
// steps per pixel: accept, address calc, store read, execute with write back
// execute waits while the result register holds an untaken transaction
// a new pixel is accepted while the previous result still waits
// after reset a clearing pass over all MAX_LINE_WORDS*STORE_LINES words (8192 by default)
// zeroes both stores with in_tready low; register writes are taken throughout
`default_nettype none
`include "assert_macros.svh"

module interleaved_bitplane_pixel_port #(
  parameter int MAX_LINE_WORDS = 32,
  parameter int STORE_LINES    = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // pos_x[15:0], pos_y[31:16], color[35:32], transparent[36]
  input  wire  [1:0]  in_tuser,   // cmd[1:0]
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // read_color[3:0], read_masked[4], changed[5]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [5:0]  cfg_paddr,
  input  wire  [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DEPTH = MAX_LINE_WORDS * STORE_LINES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;

  // configuration registers
  logic [5:0]  line_words_r;
  logic [9:0]  image_width_r;
  logic [8:0]  image_height_r;
  logic        clip_enable_r;
  logic        mask_enable_r;
  logic [63:0] remap_table_r;
  logic        cfg_wr;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic          slot_free;

  // pixel transaction
  logic [1:0]  cmd_r;
  logic [15:0] pos_x_r;
  logic [15:0] pos_y_r;
  logic [3:0]  color_r;
  logic        transp_r;

  // address stage
  logic          inside_c;
  logic [14:0]   line_base_c;
  logic [15:0]   addr_full_c;
  logic          in_store_c;
  logic [1:0]    cls_c;
  logic [1:0]    cls_r;
  logic [AW-1:0] addr_r;
  logic [3:0]    bitpos_r;

  // store
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  ibpp_pkg::word_t wr_data;
  ibpp_pkg::word_t rd_word;
  ibpp_pkg::word_t new_word;

  // execute stage
  logic [3:0] cur_color;
  logic       cur_opaque;
  logic [3:0] remap_color;
  logic [3:0] new_color;
  logic       do_write;
  logic [3:0] res_color;
  logic       res_masked;
  logic       res_changed;
  logic [1:0] res_status;

  // result register
  logic       out_valid_r;
  logic [3:0] out_color_r;
  logic       out_masked_r;
  logic       out_changed_r;
  logic [1:0] out_status_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_words_r   <= 6'd20;
      image_width_r  <= 10'd320;
      image_height_r <= 9'd200;
      clip_enable_r  <= 1'b1;
      mask_enable_r  <= 1'b0;
      remap_table_r  <= 64'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[5:3])
        ibpp_pkg::REG_LINE_WORDS:   line_words_r   <= cfg_pwdata[5:0];
        ibpp_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[9:0];
        ibpp_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[8:0];
        ibpp_pkg::REG_CLIP_ENABLE:  clip_enable_r  <= cfg_pwdata[0];
        ibpp_pkg::REG_MASK_ENABLE:  mask_enable_r  <= cfg_pwdata[0];
        ibpp_pkg::REG_REMAP_TABLE:  remap_table_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[5:3])
      ibpp_pkg::REG_LINE_WORDS:   cfg_prdata = {58'd0, line_words_r};
      ibpp_pkg::REG_IMAGE_WIDTH:  cfg_prdata = {54'd0, image_width_r};
      ibpp_pkg::REG_IMAGE_HEIGHT: cfg_prdata = {55'd0, image_height_r};
      ibpp_pkg::REG_CLIP_ENABLE:  cfg_prdata = {63'd0, clip_enable_r};
      ibpp_pkg::REG_MASK_ENABLE:  cfg_prdata = {63'd0, mask_enable_r};
      ibpp_pkg::REG_REMAP_TABLE:  cfg_prdata = remap_table_r;
      default:                    cfg_prdata = 64'd0;
    endcase
  end

  // sequencer
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r    <= in_tuser;
      pos_x_r  <= in_tdata[15:0];
      pos_y_r  <= in_tdata[31:16];
      color_r  <= in_tdata[35:32];
      transp_r <= in_tdata[36];
    end
  end

  // bounds test and word address
  assign inside_c = !pos_x_r[15] && !pos_y_r[15]
                    && (pos_x_r < {6'd0, image_width_r})
                    && (pos_y_r < {7'd0, image_height_r});
  assign line_base_c = 15'(pos_y_r[8:0]) * 15'(line_words_r);
  assign addr_full_c = {1'b0, line_base_c} + {10'd0, pos_x_r[9:4]};
  assign in_store_c  = 32'(addr_full_c) < 32'(DEPTH);

  always_comb begin
    priority if (cmd_r == ibpp_pkg::CMD_NOP) begin
      cls_c = ibpp_pkg::CLS_NOP;
    end else if (!inside_c && clip_enable_r && cmd_r != ibpp_pkg::CMD_REMAP) begin
      cls_c = ibpp_pkg::CLS_CLIP;
    end else if (!inside_c || !in_store_c) begin
      cls_c = ibpp_pkg::CLS_RANGE;
    end else begin
      cls_c = ibpp_pkg::CLS_ACCESS;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      cls_r    <= cls_c;
      addr_r   <= AW'(addr_full_c);
      bitpos_r <= ~pos_x_r[3:0];
    end
  end

  // store
  ibpp_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state_r == ST_READ),
    .rd_addr (addr_r),
    .rd_data (rd_word)
  );

  // read-modify-write of the addressed pixel
  always_comb begin
    for (int p = 0; p < ibpp_pkg::NUM_PLANES; p++) begin
      cur_color[p] = rd_word.planes[{2'(p), bitpos_r}];
    end
    cur_opaque  = rd_word.mask[bitpos_r];
    remap_color = remap_table_r[{cur_color, 2'b00} +: 4];

    new_word    = rd_word;
    new_color   = cur_color;
    do_write    = 1'b0;
    res_color   = 4'd0;
    res_masked  = 1'b0;
    res_changed = 1'b0;
    res_status  = ibpp_pkg::STAT_DONE;

    unique case (cls_r)
      ibpp_pkg::CLS_NOP: ;
      ibpp_pkg::CLS_CLIP: begin
        res_status = ibpp_pkg::STAT_CLIPPED;
        res_masked = (cmd_r == ibpp_pkg::CMD_GET) && mask_enable_r;
      end
      ibpp_pkg::CLS_RANGE: begin
        res_status = ibpp_pkg::STAT_RANGE;
      end
      ibpp_pkg::CLS_ACCESS: begin
        if (cmd_r == ibpp_pkg::CMD_PUT) begin
          if (transp_r) begin
            if (mask_enable_r) begin
              new_word.mask[bitpos_r] = 1'b0;
              new_color               = 4'd0;
              do_write                = 1'b1;
            end
          end else begin
            if (mask_enable_r) new_word.mask[bitpos_r] = 1'b1;
            new_color = color_r;
            do_write  = 1'b1;
          end
        end else if (mask_enable_r && !cur_opaque) begin
          res_masked = 1'b1;
        end else begin
          res_color = cur_color;
          if (cmd_r == ibpp_pkg::CMD_REMAP && remap_color != cur_color) begin
            if (mask_enable_r) new_word.mask[bitpos_r] = 1'b1;
            new_color   = remap_color;
            do_write    = 1'b1;
            res_changed = 1'b1;
          end
        end
      end
      default: ;
    endcase

    for (int p = 0; p < ibpp_pkg::NUM_PLANES; p++) begin
      new_word.planes[{2'(p), bitpos_r}] = new_color[p];
    end
  end

  assign wr_en   = (state_r == ST_CLEAR) || (state_r == ST_EXEC && slot_free && do_write);
  assign wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
  assign wr_data = (state_r == ST_CLEAR) ? '0 : new_word;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EXEC && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC && slot_free) begin
      out_color_r   <= res_color;
      out_masked_r  <= res_masked;
      out_changed_r <= res_changed;
      out_status_r  <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_changed_r, out_masked_r, out_color_r};
  assign out_tuser  = out_status_r;

  `ASSERT_IMPLIES(a_no_accept_in_clear, state_r == ST_CLEAR, !in_tready)
  `ASSERT_IMPLIES(a_write_only_when_due, wr_en, state_r == ST_CLEAR || state_r == ST_EXEC)
  `ASSERT_IMPLIES(a_no_write_off_image, state_r == ST_EXEC && cls_r != ibpp_pkg::CLS_ACCESS, !wr_en)
  `ASSERT_NEXT(a_result_follows_exec, state_r == ST_EXEC && slot_free, out_valid_r)

endmodule

`default_nettype wire

>>> hdl/ibpp_store.sv
// plane and mask memories with one write port and one registered read port
`default_nettype none

module ibpp_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire                 clk,
  input  wire                 wr_en,
  input  wire  [AW-1:0]       wr_addr,
  input  ibpp_pkg::word_t     wr_data,
  input  wire                 rd_en,
  input  wire  [AW-1:0]       rd_addr,
  output ibpp_pkg::word_t     rd_data
);

  logic [ibpp_pkg::NUM_PLANES*ibpp_pkg::WORD_BITS-1:0] plane_mem [DEPTH];
  logic [ibpp_pkg::WORD_BITS-1:0]                      mask_mem  [DEPTH];

  ibpp_pkg::word_t rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      plane_mem[wr_addr] <= wr_data.planes;
      mask_mem[wr_addr]  <= wr_data.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r.planes <= plane_mem[rd_addr];
      rd_word_r.mask   <= mask_mem[rd_addr];
    end
  end

  assign rd_data = rd_word_r;

endmodule

`default_nettype wire
